### hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

   // Command codes
   localparam logic [2:0] CMD_PUT_BYTE     = 3'd0;
   localparam logic [2:0] CMD_SET_CURSOR   = 3'd1;
   localparam logic [2:0] CMD_DRAW_CHAR    = 3'd2;
   localparam logic [2:0] CMD_READ_CELL    = 3'd3;
   localparam logic [2:0] CMD_CLEAR_SCREEN = 3'd4;

   // Control characters
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] BLANK_CHAR     = 8'h00;

   // Attributes
   localparam logic [7:0] MAX_ATTRIBUTE   = 8'h8F;
   localparam logic [7:0] RESET_ATTRIBUTE = 8'h0F;

   // Register indexes
   localparam logic REG_TEXT_COLOR    = 1'b0;
   localparam logic REG_CURSOR_HIDDEN = 1'b1;

   // Status codes
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] byte_value;
      logic [4:0] target_row;
      logic [6:0] target_column;
      logic [7:0] cell_color;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic [11:0] cursor_address;
      logic [7:0]  read_character;
      logic [7:0]  read_attribute;
   } rsp_item_type;

   // Kind of full-screen sweep
   typedef enum logic [1:0] {
      SWEEP_INIT   = 2'd0,
      SWEEP_CLEAR  = 2'd1,
      SWEEP_SCROLL = 2'd2
   } sweep_kind_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic start_clear;
      logic start_scroll;
      logic sweep;
      logic finish;
   } tcw_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scroll;
      logic do_clear;
      logic do_read;
      logic sweep_done;
   } tcw_stat_type;

endpackage

`default_nettype wire

### hw/rtl/tcw_ctrl.sv
// Sequencer of the text console writer: item intake, execution, read wait and sweeps.
`default_nettype none

module tcw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire tcw_pkg::tcw_stat_type stat,
   output logic                      busy,
   output tcw_pkg::tcw_cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_RDWAIT = 5'b01000,
      ST_SWEEP  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.do_clear) begin
               cmd.start_clear = 1'b1;
               state_in        = ST_SWEEP;
            end else if (stat.need_scroll) begin
               cmd.start_scroll = 1'b1;
               state_in         = ST_SWEEP;
            end else if (stat.do_read) begin
               state_in = ST_RDWAIT;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_RDWAIT: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // Execution lasts a single cycle per item
   a_exec_single: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("exec held for more than one cycle");

endmodule

`default_nettype wire

### hw/rtl/tcw_datapath.sv
// Screen store, cursor, sweep counter and result register of the text console writer.
`default_nettype none

module tcw_datapath #(
   parameter int ROWS    = 25,
   parameter int COLUMNS = 80
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tcw_pkg::tcw_cmd_type  cmd,
   input  wire tcw_pkg::req_item_type req_item,
   input  wire logic [7:0]            text_color,
   input  wire logic                  cursor_hidden,
   output tcw_pkg::tcw_stat_type      stat,
   output tcw_pkg::rsp_item_type      rsp_item,
   output logic                       rsp_strobe
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CW         = $clog2(CELL_COUNT + 1);

   localparam logic [5:0]    ROW_LIMIT   = 6'(ROWS);
   localparam logic [7:0]    COL_LIMIT   = 8'(COLUMNS);
   localparam logic [6:0]    COL_LAST    = 7'(COLUMNS - 1);
   localparam logic [11:0]   COL_MULT    = 12'(COLUMNS);
   localparam logic [11:0]   HIDDEN_ADDR = 12'(CELL_COUNT + COLUMNS);
   localparam logic [CW-1:0] CNT_DONE    = CW'(CELL_COUNT);
   localparam logic [CW-1:0] CNT_MOVE    = CW'(MOVE_COUNT);
   localparam logic [CW-1:0] CNT_STRIDE  = CW'(COLUMNS);

   tcw_pkg::req_item_type   req_ff;
   tcw_pkg::rsp_item_type   rsp_ff, rsp_in;
   logic                    strobe_ff;
   logic [4:0]              row_ff, row_in;
   logic [6:0]              col_ff, col_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   tcw_pkg::sweep_kind_type kind_ff, kind_in;

   logic [15:0]   mem [CELL_COUNT];
   logic [15:0]   rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata;

   logic          in_range, color_ok, rejected, read_ok;
   logic [11:0]   target_lin, cur_lin, next_lin;
   logic [7:0]    col_inc;
   logic [5:0]    row_inc;
   logic          at_origin, wrap;
   logic [CW-1:0] cnt_prev;
   logic [7:0]    blank_attr;

   // Request decode
   assign in_range   = ({1'b0, req_ff.target_row} < ROW_LIMIT)
                    && ({1'b0, req_ff.target_column} < COL_LIMIT);
   assign color_ok   = (req_ff.cell_color <= tcw_pkg::MAX_ATTRIBUTE);
   assign target_lin = 12'(req_ff.target_row) * COL_MULT + 12'(req_ff.target_column);
   assign cur_lin    = 12'(row_ff) * COL_MULT + 12'(col_ff);
   assign next_lin   = 12'(row_in) * COL_MULT + 12'(col_in);
   assign col_inc    = {1'b0, col_ff} + 8'd1;
   assign row_inc    = {1'b0, row_ff} + 6'd1;
   assign at_origin  = (col_ff == 7'd0) && (row_ff == 5'd0);
   assign wrap       = (req_ff.byte_value == tcw_pkg::CHAR_NEWLINE) || (col_inc == COL_LIMIT);
   assign read_ok    = (req_ff.command == tcw_pkg::CMD_READ_CELL) && in_range;

   always_comb begin
      rejected = 1'b0;
      case (req_ff.command)
         tcw_pkg::CMD_SET_CURSOR: rejected = !in_range;
         tcw_pkg::CMD_DRAW_CHAR:  rejected = !(in_range && color_ok);
         tcw_pkg::CMD_READ_CELL:  rejected = !in_range;
         default:                 rejected = 1'b0;
      endcase
   end

   // Status toward the controller
   always_comb begin
      stat             = '0;
      stat.do_clear    = (req_ff.command == tcw_pkg::CMD_CLEAR_SCREEN);
      stat.do_read     = read_ok;
      stat.sweep_done  = (cnt_ff == CNT_DONE);
      stat.need_scroll = (req_ff.command == tcw_pkg::CMD_PUT_BYTE)
                      && (req_ff.byte_value != tcw_pkg::CHAR_BACKSPACE)
                      && (req_ff.byte_value != tcw_pkg::CHAR_RETURN)
                      && wrap && (row_inc == ROW_LIMIT);
   end

   // Sweep write source: one cell behind the counter
   assign cnt_prev   = cnt_ff - CW'(1);
   assign blank_attr = (kind_ff == tcw_pkg::SWEEP_INIT) ? tcw_pkg::RESET_ATTRIBUTE : text_color;

   // Cursor update and cell writes
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      mem_we    = 1'b0;
      mem_waddr = cur_lin[AW-1:0];
      mem_wdata = {text_color, req_ff.byte_value};
      if (cmd.exec) begin
         case (req_ff.command)
            tcw_pkg::CMD_PUT_BYTE: begin
               if (req_ff.byte_value == tcw_pkg::CHAR_BACKSPACE) begin
                  if (!at_origin) begin
                     if (col_ff == 7'd0) begin
                        col_in = COL_LAST;
                        row_in = row_ff - 5'd1;
                     end else begin
                        col_in = col_ff - 7'd1;
                     end
                     // previous cell in reading order, across a row break too
                     mem_we    = (text_color <= tcw_pkg::MAX_ATTRIBUTE);
                     mem_waddr = AW'(cur_lin - 12'd1);
                     mem_wdata = {text_color, tcw_pkg::BLANK_CHAR};
                  end
               end else if (req_ff.byte_value == tcw_pkg::CHAR_RETURN) begin
                  col_in = 7'd0;
               end else begin
                  mem_we = (req_ff.byte_value != tcw_pkg::CHAR_NEWLINE);
                  if (wrap) begin
                     col_in = 7'd0;
                     // bottom row stays put, the sweep moves the text up
                     if (row_inc != ROW_LIMIT) begin
                        row_in = row_inc[4:0];
                     end
                  end else begin
                     col_in = col_inc[6:0];
                  end
               end
            end
            tcw_pkg::CMD_SET_CURSOR: begin
               if (in_range) begin
                  row_in = req_ff.target_row;
                  col_in = req_ff.target_column;
               end
            end
            tcw_pkg::CMD_DRAW_CHAR: begin
               mem_we    = in_range && color_ok;
               mem_waddr = target_lin[AW-1:0];
               mem_wdata = {req_ff.cell_color, req_ff.byte_value};
            end
            tcw_pkg::CMD_CLEAR_SCREEN: begin
               row_in = 5'd0;
               col_in = 7'd0;
            end
            default: begin
               row_in = row_ff;
            end
         endcase
      end else if (cmd.sweep && (cnt_ff != '0)) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_prev[AW-1:0];
         if ((kind_ff == tcw_pkg::SWEEP_SCROLL) && (cnt_prev < CNT_MOVE)) begin
            mem_wdata = rd_data_ff;
         end else begin
            mem_wdata = {blank_attr, tcw_pkg::BLANK_CHAR};
         end
      end
   end

   // Read port: one row ahead during a scroll, else the target cell
   always_comb begin
      if (cmd.sweep) begin
         mem_re    = (kind_ff == tcw_pkg::SWEEP_SCROLL) && (cnt_ff < CNT_MOVE);
         mem_raddr = AW'(cnt_ff + CNT_STRIDE);
      end else begin
         mem_re    = in_range;
         mem_raddr = target_lin[AW-1:0];
      end
   end

   // Sweep counter
   always_comb begin
      cnt_in  = cnt_ff;
      kind_in = kind_ff;
      if (cmd.start_clear) begin
         cnt_in  = '0;
         kind_in = tcw_pkg::SWEEP_CLEAR;
      end else if (cmd.start_scroll) begin
         cnt_in  = '0;
         kind_in = tcw_pkg::SWEEP_SCROLL;
      end else if (cmd.sweep && (cnt_ff != CNT_DONE)) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   // Result assembly
   always_comb begin
      rsp_in                = '0;
      rsp_in.status         = rejected ? tcw_pkg::STATUS_REJECTED : tcw_pkg::STATUS_DONE;
      rsp_in.cursor_row     = row_in;
      rsp_in.cursor_column  = col_in;
      rsp_in.cursor_address = cursor_hidden ? HIDDEN_ADDR : next_lin;
      if (read_ok) begin
         rsp_in.read_character = rd_data_ff[7:0];
         rsp_in.read_attribute = rd_data_ff[15:8];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= 5'd0;
         col_ff    <= 7'd0;
         cnt_ff    <= '0;
         kind_ff   <= tcw_pkg::SWEEP_INIT;
         strobe_ff <= 1'b0;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         cnt_ff    <= cnt_in;
         kind_ff   <= kind_in;
         strobe_ff <= cmd.finish;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // Screen store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = strobe_ff;

   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (int'(mem_waddr) < CELL_COUNT))
      else $error("cell write beyond the screen");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, row_ff} < ROW_LIMIT) && ({1'b0, col_ff} < COL_LIMIT))
      else $error("cursor off the screen");

endmodule

`default_nettype wire

### hw/rtl/text_console_writer.sv
// Top level of the text console writer: registers, sequencer and datapath.
//
//  channel   direction  handshake              payload
//  request   in         start, busy            req_item (tcw_pkg::req_item_type)
//  result    out        rsp_strobe             rsp_item (tcw_pkg::rsp_item_type)
//  csr       in/out     psel, penable, pready  paddr, pwdata, prdata
//
// An item is taken when start is high and busy low. Most commands return their
// result from the execute state; read_cell also passes a read-wait state, as the
// screen store read is registered. A scroll or clear_screen sweeps every cell
// through the single write port before it returns its result. After reset the
// store is blanked by the same sweep, with busy high. The receiver cannot stall:
// each result shows for one cycle with rsp_strobe.
`default_nettype none

module text_console_writer #(
   parameter int ROWS    = 25,
   parameter int COLUMNS = 80
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire tcw_pkg::req_item_type req_item,
   output logic                       rsp_strobe,
   output tcw_pkg::rsp_item_type      rsp_item,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   tcw_pkg::tcw_cmd_type  cmd;
   tcw_pkg::tcw_stat_type stat;

   logic [7:0] text_color_ff;
   logic       cursor_hidden_ff;
   logic       csr_write;
   logic       csr_index;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff    <= tcw_pkg::RESET_ATTRIBUTE;
         cursor_hidden_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == tcw_pkg::REG_TEXT_COLOR) begin
            text_color_ff <= pwdata[7:0];
         end else begin
            cursor_hidden_ff <= pwdata[0];
         end
      end
   end

   assign prdata = (csr_index == tcw_pkg::REG_CURSOR_HIDDEN) ? {31'd0, cursor_hidden_ff}
                                                             : {24'd0, text_color_ff};

   tcw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   tcw_datapath #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_item      (req_item),
      .text_color    (text_color_ff),
      .cursor_hidden (cursor_hidden_ff),
      .stat          (stat),
      .rsp_item      (rsp_item),
      .rsp_strobe    (rsp_strobe)
   );

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on two cycles in a row");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

endmodule

`default_nettype wire

### sim/text_console_writer_tb.sv
// Self-checking testbench for the text console writer: command stimulus, cell store model, result check.
module text_console_writer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS           = 25;
   localparam int COLUMNS        = 80;
   localparam int CELLS          = ROWS * COLUMNS;
   localparam int RANDOM_CHUNK   = 200;
   localparam int WATCHDOG_LIMIT = 20000;

   localparam logic [2:0] ADDR_TEXT_COLOR    = {tcw_pkg::REG_TEXT_COLOR, 2'b00};
   localparam logic [2:0] ADDR_CURSOR_HIDDEN = {tcw_pkg::REG_CURSOR_HIDDEN, 2'b00};

   // One command waiting to be sent; hold_for_drain waits out every open result first
   typedef struct {
      tcw_pkg::req_item_type item;
      bit                    hold_for_drain;
   } console_cmd_type;

   logic                  clock;
   logic                  reset    = 1'b1;
   logic                  start    = 1'b0;
   tcw_pkg::req_item_type req_item = '0;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [2:0]            paddr    = '0;
   logic [31:0]           pwdata   = '0;
   logic                  busy;
   logic                  rsp_strobe;
   tcw_pkg::rsp_item_type rsp_item;
   logic [31:0]           prdata;
   logic                  pready;

   // Console model state
   logic [15:0]  screen_model [CELLS];
   int unsigned  cursor_row_model;
   int unsigned  cursor_col_model;
   logic [7:0]   color_model;
   logic         hidden_model;

   console_cmd_type       cmd_backlog[$];
   tcw_pkg::rsp_item_type expected_replies[$];
   logic                  req_taken = 1'b0;
   int unsigned           sender_idle_pct = 9;
   int unsigned           failures = 0;
   int unsigned           stall_cycles = 0;

   text_console_writer #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one command to the console model and form its result
   task automatic console_execute(input tcw_pkg::req_item_type c,
                                  output tcw_pkg::rsp_item_type r);
      int unsigned idx;
      logic        in_range;
      r        = '0;
      r.status = tcw_pkg::STATUS_DONE;
      in_range = (c.target_row < ROWS) && (c.target_column < COLUMNS);
      case (c.command)
         tcw_pkg::CMD_PUT_BYTE: begin
            if (c.byte_value == tcw_pkg::CHAR_BACKSPACE) begin
               // nothing moves at the origin
               if (cursor_col_model != 0 || cursor_row_model != 0) begin
                  if (cursor_col_model == 0) begin
                     cursor_col_model = COLUMNS - 1;
                     cursor_row_model--;
                  end else begin
                     cursor_col_model--;
                  end
                  // colors above the max attribute leave the cell alone
                  if (color_model <= tcw_pkg::MAX_ATTRIBUTE)
                     screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
                        {color_model, tcw_pkg::BLANK_CHAR};
               end
            end else if (c.byte_value == tcw_pkg::CHAR_RETURN) begin
               cursor_col_model = 0;
            end else begin
               if (c.byte_value == tcw_pkg::CHAR_NEWLINE)
                  cursor_col_model = COLUMNS - 1;
               else
                  screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
                     {color_model, c.byte_value};
               cursor_col_model++;
               if (cursor_col_model >= COLUMNS) begin
                  cursor_col_model = 0;
                  cursor_row_model++;
               end
               // scroll one full row, blank the bottom row with the text color
               if (cursor_row_model >= ROWS) begin
                  cursor_row_model = ROWS - 1;
                  for (idx = 0; idx < CELLS - COLUMNS; idx++)
                     screen_model[idx] = screen_model[idx + COLUMNS];
                  for (idx = CELLS - COLUMNS; idx < CELLS; idx++)
                     screen_model[idx] = {color_model, tcw_pkg::BLANK_CHAR};
               end
            end
         end
         tcw_pkg::CMD_SET_CURSOR: begin
            if (in_range) begin
               cursor_row_model = c.target_row;
               cursor_col_model = c.target_column;
            end else begin
               r.status = tcw_pkg::STATUS_REJECTED;
            end
         end
         tcw_pkg::CMD_DRAW_CHAR: begin
            if (in_range && c.cell_color <= tcw_pkg::MAX_ATTRIBUTE)
               screen_model[c.target_row * COLUMNS + c.target_column] =
                  {c.cell_color, c.byte_value};
            else
               r.status = tcw_pkg::STATUS_REJECTED;
         end
         tcw_pkg::CMD_READ_CELL: begin
            if (in_range) begin
               idx              = c.target_row * COLUMNS + c.target_column;
               r.read_character = screen_model[idx][7:0];
               r.read_attribute = screen_model[idx][15:8];
            end else begin
               r.status = tcw_pkg::STATUS_REJECTED;
            end
         end
         tcw_pkg::CMD_CLEAR_SCREEN: begin
            for (idx = 0; idx < CELLS; idx++)
               screen_model[idx] = {color_model, tcw_pkg::BLANK_CHAR};
            cursor_row_model = 0;
            cursor_col_model = 0;
         end
         default: ;
      endcase
      r.cursor_row    = 5'(cursor_row_model);
      r.cursor_column = 7'(cursor_col_model);
      if (hidden_model)
         r.cursor_address = 12'(ROWS * COLUMNS + COLUMNS);
      else
         r.cursor_address = 12'(cursor_row_model * COLUMNS + cursor_col_model);
   endtask

   function automatic void push_cmd(logic [2:0] op, logic [7:0] ch, logic [4:0] row,
                                    logic [6:0] col, logic [7:0] attr);
      console_cmd_type e;
      e.item.command       = op;
      e.item.byte_value    = ch;
      e.item.target_row    = row;
      e.item.target_column = col;
      e.item.cell_color    = attr;
      e.hold_for_drain     = 1'b0;
      cmd_backlog.push_back(e);
   endfunction

   // Random command, weighted toward in-range positions and the bottom row
   function automatic tcw_pkg::req_item_type random_cmd();
      tcw_pkg::req_item_type c;
      int unsigned           pick;
      c.command       = tcw_pkg::CMD_PUT_BYTE;
      c.byte_value    = 8'($urandom_range(0, 255));
      c.target_row    = 5'($urandom_range(0, 31));
      c.target_column = 7'($urandom_range(0, 127));
      c.cell_color    = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            c.byte_value = tcw_pkg::CHAR_BACKSPACE;
         else if (pick < 15)
            c.byte_value = tcw_pkg::CHAR_RETURN;
         else if (pick < 19)
            c.byte_value = tcw_pkg::CHAR_NEWLINE;
      end else if (pick < 57) begin
         c.command = tcw_pkg::CMD_SET_CURSOR;
         if ($urandom_range(0, 9) < 8) begin
            c.target_row    = ($urandom_range(0, 2) == 0) ? 5'(ROWS - 1)
                                                          : 5'($urandom_range(0, ROWS - 1));
            c.target_column = 7'($urandom_range(0, COLUMNS - 1));
         end
      end else if (pick < 72) begin
         c.command = tcw_pkg::CMD_DRAW_CHAR;
         if ($urandom_range(0, 9) < 8) begin
            c.target_row    = 5'($urandom_range(0, ROWS - 1));
            c.target_column = 7'($urandom_range(0, COLUMNS - 1));
         end
         if ($urandom_range(0, 4) != 0)
            c.cell_color = 8'($urandom_range(0, tcw_pkg::MAX_ATTRIBUTE));
      end else if (pick < 93) begin
         c.command = tcw_pkg::CMD_READ_CELL;
         if ($urandom_range(0, 9) < 8) begin
            c.target_row    = 5'($urandom_range(0, ROWS - 1));
            c.target_column = 7'($urandom_range(0, COLUMNS - 1));
         end
      end else if (pick < 95) begin
         c.command = tcw_pkg::CMD_CLEAR_SCREEN;
      end else begin
         c.command = 3'($urandom_range(5, 7));
      end
      return c;
   endfunction

   // APB write: setup cycle, then access cycle until pready
   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Wait until every item is sent, every result is back and the block is idle
   task automatic wait_until_quiet();
      @(negedge clock);
      while (cmd_backlog.size() != 0 || start || expected_replies.size() != 0 || busy)
         @(negedge clock);
   endtask

   // Driver: presents items at the falling edge
   always @(negedge clock) begin : driver
      logic launch;
      launch = 1'b0;
      if (!reset && !(start && !req_taken)) begin
         if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
             !(cmd_backlog[0].hold_for_drain && expected_replies.size() != 0)) begin
            req_item <= cmd_backlog[0].item;
            void'(cmd_backlog.pop_front());
            launch = 1'b1;
         end
         start <= launch;
      end
   end

   // Monitor: register writes, result check, prediction and watchdog
   always @(posedge clock) begin : monitor
      tcw_pkg::rsp_item_type want;
      tcw_pkg::rsp_item_type predicted;
      logic                  activity;
      activity = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (psel && penable && pwrite && pready) begin
            activity = 1'b1;
            case (paddr)
               ADDR_TEXT_COLOR:    color_model  = pwdata[7:0];
               ADDR_CURSOR_HIDDEN: hidden_model = pwdata[0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            activity = 1'b1;
            if (expected_replies.size() == 0) begin
               $error("result with no command outstanding");
               failures++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  failures++;
               end
               if (rsp_item.cursor_row !== want.cursor_row) begin
                  $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                         rsp_item.cursor_row);
                  failures++;
               end
               if (rsp_item.cursor_column !== want.cursor_column) begin
                  $error("cursor_column: expected %0d, got %0d", want.cursor_column,
                         rsp_item.cursor_column);
                  failures++;
               end
               if (rsp_item.cursor_address !== want.cursor_address) begin
                  $error("cursor_address: expected %0d, got %0d", want.cursor_address,
                         rsp_item.cursor_address);
                  failures++;
               end
               if (rsp_item.read_character !== want.read_character) begin
                  $error("read_character: expected %0h, got %0h", want.read_character,
                         rsp_item.read_character);
                  failures++;
               end
               if (rsp_item.read_attribute !== want.read_attribute) begin
                  $error("read_attribute: expected %0h, got %0h", want.read_attribute,
                         rsp_item.read_attribute);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            activity = 1'b1;
            console_execute(req_item, predicted);
            expected_replies.push_back(predicted);
         end
         if (activity) begin
            stall_cycles = 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            stall_cycles++;
         end
      end
   end

   initial begin : stimulus
      int unsigned     idx;
      int unsigned     phase;
      logic [7:0]      phase_color;
      logic            phase_hidden;
      console_cmd_type e;

      // model reset state: blank cells, white on black
      for (idx = 0; idx < CELLS; idx++)
         screen_model[idx] = {tcw_pkg::RESET_ATTRIBUTE, tcw_pkg::BLANK_CHAR};
      cursor_row_model = 0;
      cursor_col_model = 0;
      color_model      = tcw_pkg::RESET_ATTRIBUTE;
      hidden_model     = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // the block blanks its store after reset
      wait_until_quiet();

      // Directed: reset color, cursor shown
      write_register(ADDR_TEXT_COLOR, 32'(tcw_pkg::RESET_ATTRIBUTE));
      write_register(ADDR_CURSOR_HIDDEN, 32'd0);
      push_cmd(tcw_pkg::CMD_READ_CELL, 8'h00, 5'd0, 7'd0, 8'h00);
      // backspace at origin
      push_cmd(tcw_pkg::CMD_PUT_BYTE, tcw_pkg::CHAR_BACKSPACE, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_PUT_BYTE, 8'h41, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_PUT_BYTE, 8'hFF, 5'd31, 7'd127, 8'hFF);
      push_cmd(tcw_pkg::CMD_PUT_BYTE, tcw_pkg::CHAR_RETURN, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_SET_CURSOR, 8'h00, 5'd1, 7'd0, 8'h00);
      // back to previous row
      push_cmd(tcw_pkg::CMD_PUT_BYTE, tcw_pkg::CHAR_BACKSPACE, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_READ_CELL, 8'h00, 5'd0, 7'(COLUMNS - 1), 8'h00);
      push_cmd(tcw_pkg::CMD_DRAW_CHAR, 8'h5A, 5'(ROWS - 1), 7'd5, tcw_pkg::MAX_ATTRIBUTE);
      push_cmd(tcw_pkg::CMD_SET_CURSOR, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1), 8'h00);
      // wrap past bottom
      push_cmd(tcw_pkg::CMD_PUT_BYTE, 8'h00, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_READ_CELL, 8'h00, 5'(ROWS - 2), 7'd5, 8'h00);
      // newline scroll
      push_cmd(tcw_pkg::CMD_PUT_BYTE, tcw_pkg::CHAR_NEWLINE, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_SET_CURSOR, 8'h00, 5'(ROWS), 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_SET_CURSOR, 8'h00, 5'd31, 7'd127, 8'h00);
      // color too high
      push_cmd(tcw_pkg::CMD_DRAW_CHAR, 8'hFF, 5'd0, 7'd0, 8'h90);
      push_cmd(tcw_pkg::CMD_DRAW_CHAR, 8'hFF, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_DRAW_CHAR, 8'h00, 5'd31, 7'd127, 8'h00);
      push_cmd(3'd7, 8'hFF, 5'd31, 7'd127, 8'hFF);                  // unused code
      push_cmd(tcw_pkg::CMD_CLEAR_SCREEN, 8'h00, 5'd0, 7'd0, 8'h00);
      wait_until_quiet();

      // Directed: color above the max attribute, cursor hidden
      write_register(ADDR_TEXT_COLOR, 32'hFF);
      write_register(ADDR_CURSOR_HIDDEN, 32'd1);
      push_cmd(tcw_pkg::CMD_SET_CURSOR, 8'h00, 5'(ROWS - 1), 7'd10, 8'h00);
      // cell left alone
      push_cmd(tcw_pkg::CMD_PUT_BYTE, tcw_pkg::CHAR_BACKSPACE, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_READ_CELL, 8'h00, 5'(ROWS - 1), 7'd9, 8'h00);
      push_cmd(tcw_pkg::CMD_PUT_BYTE, tcw_pkg::CHAR_NEWLINE, 5'd0, 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_READ_CELL, 8'h00, 5'(ROWS - 1), 7'd0, 8'h00);
      push_cmd(tcw_pkg::CMD_CLEAR_SCREEN, 8'h00, 5'd0, 7'd0, 8'h00);
      wait_until_quiet();

      // Random chunks over several register settings and sender idle rates
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               phase_color = 8'h00; phase_hidden = 1'b0; sender_idle_pct = 9;
            end
            1: begin
               phase_color = tcw_pkg::MAX_ATTRIBUTE; phase_hidden = 1'b1;
               sender_idle_pct = 52;
            end
            2: begin
               phase_color = 8'h90; phase_hidden = 1'b0; sender_idle_pct = 0;
            end
            default: begin
               phase_color     = 8'($urandom_range(0, 255));
               phase_hidden    = 1'($urandom_range(0, 1));
               sender_idle_pct = 0;
            end
         endcase
         write_register(ADDR_TEXT_COLOR, 32'(phase_color));
         write_register(ADDR_CURSOR_HIDDEN, 32'(phase_hidden));
         for (idx = 0; idx < RANDOM_CHUNK; idx++) begin
            e.item           = random_cmd();
            e.hold_for_drain = (idx == RANDOM_CHUNK / 2);
            cmd_backlog.push_back(e);
         end
         wait_until_quiet();
      end

      repeat (50) @(posedge clock);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### text_console_writer.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer.sv
sim/text_console_writer_tb.sv
